>>> sv/bwc_pkg.sv
`default_nettype none

package bwc_pkg;

  // Largest legal image or window dimension
  localparam int MAX_DIM = 4096;

  localparam int DIM_W   = 13;  // src_width, src_height, win_width, win_height
  localparam int OFS_W   = 12;  // win_left, win_top
  localparam int BYTE_W  = 8;
  localparam int POS_W   = 14;  // byte position in a source row
  localparam int ROW_W   = 12;  // source row index
  localparam int LIM_W   = 15;  // byte limits derived from 3 * dimension
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_LEFT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_TOP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_HEIGHT = 3'd5;

  // Values derived from the configuration registers
  typedef struct packed {
    logic             bad;         // window does not fit in the image
    logic [LIM_W-1:0] stride;      // source row length in bytes, padded to 4
    logic [DIM_W-1:0] src_height;
    logic [DIM_W-1:0] row_first;   // first kept source row (file order)
    logic [POS_W-1:0] row_last;    // last kept source row
    logic [LIM_W-1:0] pos_first;   // first kept byte in a row
    logic [LIM_W-1:0] pos_last;    // last kept byte in a row
    logic [1:0]       pad;         // destination padding bytes per row
  } cfg_t;

  // What one accepted source byte turns into
  typedef struct packed {
    logic              emit;       // at least one result
    logic              bad;
    logic [BYTE_W-1:0] data;
    logic              last;       // pixel byte closes the frame
    logic [1:0]        pad_cnt;    // padding bytes after the pixel byte
    logic              last_row;
  } item_t;

  function automatic logic dim_ok(logic [DIM_W-1:0] d);
    return (d != '0) && (32'(d) <= MAX_DIM);
  endfunction

endpackage

`default_nettype wire

>>> sv/bwc_cfg.sv
`default_nettype none

module bwc_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [bwc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bwc_pkg::DIM_W-1:0]      cfg_data,
  output bwc_pkg::cfg_t                       cfg
);
  import bwc_pkg::*;

  logic [DIM_W-1:0] src_width;
  logic [DIM_W-1:0] src_height;
  logic [OFS_W-1:0] win_left;
  logic [OFS_W-1:0] win_top;
  logic [DIM_W-1:0] win_width;
  logic [DIM_W-1:0] win_height;

  logic [POS_W-1:0] right_sum;
  logic [POS_W-1:0] top_sum;
  logic [POS_W-1:0] row_end;
  logic [DIM_W-1:0] bottom;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= DIM_W'(1);
      src_height <= DIM_W'(1);
      win_left   <= '0;
      win_top    <= '0;
      win_width  <= DIM_W'(1);
      win_height <= DIM_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SRC_WIDTH:  src_width  <= cfg_data;
        REG_SRC_HEIGHT: src_height <= cfg_data;
        REG_WIN_LEFT:   win_left   <= cfg_data[OFS_W-1:0];
        REG_WIN_TOP:    win_top    <= cfg_data[OFS_W-1:0];
        REG_WIN_WIDTH:  win_width  <= cfg_data;
        REG_WIN_HEIGHT: win_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign right_sum = POS_W'(win_left) + POS_W'(win_width);
  assign top_sum   = POS_W'(win_top) + POS_W'(win_height);
  assign bottom    = DIM_W'(POS_W'(src_height) - top_sum);
  assign row_end   = POS_W'(bottom) + POS_W'(win_height);

  always_comb begin
    cfg.bad = !dim_ok(src_width) || !dim_ok(src_height) ||
              !dim_ok(win_width) || !dim_ok(win_height) ||
              (right_sum > POS_W'(src_width)) || (top_sum > POS_W'(src_height));
    // 3*w + 3, low two bits cleared
    cfg.stride     = ((LIM_W'(src_width) << 1) + LIM_W'(src_width) + LIM_W'(3))
                     & ~LIM_W'(3);
    cfg.src_height = src_height;
    cfg.row_first  = bottom;
    cfg.row_last   = row_end - POS_W'(1);
    cfg.pos_first  = (LIM_W'(win_left) << 1) + LIM_W'(win_left);
    cfg.pos_last   = (LIM_W'(right_sum) << 1) + LIM_W'(right_sum) - LIM_W'(1);
    cfg.pad        = win_width[1:0];
  end

endmodule

`default_nettype wire

>>> sv/bwc_scan.sv
`default_nettype none

module bwc_scan (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       accept,
  input  wire logic [bwc_pkg::BYTE_W-1:0] src_byte,
  input  wire bwc_pkg::cfg_t              cfg,
  output bwc_pkg::item_t                  item
);
  import bwc_pkg::*;

  logic [POS_W-1:0] row_byte_pos;
  logic [ROW_W-1:0] row_index;
  logic [POS_W-1:0] row_byte_pos_next;
  logic [ROW_W-1:0] row_index_next;

  logic in_rows;
  logic in_cols;
  logic row_end;
  logic last_row;

  assign in_rows  = (DIM_W'(row_index) >= cfg.row_first) &&
                    (POS_W'(row_index) <= cfg.row_last);
  assign in_cols  = (LIM_W'(row_byte_pos) >= cfg.pos_first) &&
                    (LIM_W'(row_byte_pos) <= cfg.pos_last);
  assign row_end  = LIM_W'(row_byte_pos) == cfg.pos_last;
  assign last_row = POS_W'(row_index) == cfg.row_last;

  always_comb begin
    item = '0;
    if (cfg.bad) begin
      item.emit = 1'b1;
      item.bad  = 1'b1;
    end else if (in_rows && in_cols) begin
      item.emit     = 1'b1;
      item.data     = src_byte;
      item.last_row = last_row;
      if (row_end) begin
        item.pad_cnt = cfg.pad;
        item.last    = last_row && (cfg.pad == 2'd0);
      end
    end
  end

  // Counters wrap at end of row / end of frame; they hold on a bad window
  always_comb begin
    row_byte_pos_next = row_byte_pos;
    row_index_next    = row_index;
    if (accept && !cfg.bad) begin
      if ((LIM_W'(row_byte_pos) + LIM_W'(1)) >= cfg.stride) begin
        row_byte_pos_next = '0;
        if ((DIM_W'(row_index) + DIM_W'(1)) >= cfg.src_height) begin
          row_index_next = '0;
        end else begin
          row_index_next = row_index + ROW_W'(1);
        end
      end else begin
        row_byte_pos_next = row_byte_pos + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_byte_pos <= '0;
      row_index    <= '0;
    end else begin
      row_byte_pos <= row_byte_pos_next;
      row_index    <= row_index_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/bwc_emit.sv
`default_nettype none

module bwc_emit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        accept,
  input  wire bwc_pkg::item_t              item,
  output logic                             can_take,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [bwc_pkg::BYTE_W-1:0]       out_byte,
  output logic                             is_pad,
  output logic                             frame_last,
  output logic                             bad_window
);
  import bwc_pkg::*;

  logic [1:0] pad_left;
  logic       pad_last_row;
  logic       advance;

  assign advance  = !out_valid || !out_stall;
  // a new item is taken only when no padding is pending
  assign can_take = advance && (pad_left == 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pad_left  <= '0;
    end else if (advance) begin
      if (pad_left != 2'd0) begin
        out_valid <= 1'b1;
        pad_left  <= pad_left - 2'd1;
      end else if (accept && item.emit) begin
        out_valid <= 1'b1;
        pad_left  <= item.pad_cnt;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (pad_left != 2'd0) begin
        out_byte   <= '0;
        is_pad     <= 1'b1;
        frame_last <= pad_last_row && (pad_left == 2'd1);
        bad_window <= 1'b0;
      end else if (accept) begin
        out_byte     <= item.data;
        is_pad       <= 1'b0;
        frame_last   <= item.last;
        bad_window   <= item.bad;
        pad_last_row <= item.last_row;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/bmp_window_crop.sv
`default_nettype none

// Channel  | signals                          | transfer when
// ---------+----------------------------------+----------------------------
// input    | in_valid, in_stall, src_byte     | in_valid && !in_stall
// output   | out_valid, out_stall, out_byte,  | out_valid && !out_stall
//          | is_pad, frame_last, bad_window   |
// config   | cfg_write, cfg_index, cfg_data   | cfg_write
//
// One source byte per cycle while in_stall is low. A byte that closes a kept row adds win_width%4
// padding beats, during which in_stall is high.
// Results appear in the cycle after the input transfer, from the output register.
// rst is synchronous; it clears the row counters, the output valid and
// loads the register defaults (1x1 image, 1x1 window at 0,0).
// in_stall follows out_stall in the same cycle while a result is held.

module bmp_window_crop (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // configuration
  input  wire logic                           cfg_write,
  input  wire logic [bwc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bwc_pkg::DIM_W-1:0]      cfg_data,
  // source bytes
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [bwc_pkg::BYTE_W-1:0]     src_byte,
  // cropped bytes
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [bwc_pkg::BYTE_W-1:0]          out_byte,
  output logic                                is_pad,
  output logic                                frame_last,
  output logic                                bad_window
);
  import bwc_pkg::*;

  cfg_t  cfg;
  item_t item;
  logic  can_take;
  logic  accept;

  assign in_stall = !can_take;
  assign accept   = in_valid && can_take;

  // register file and derived window limits
  bwc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // row/column tracking and keep decision for the incoming byte
  bwc_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .src_byte (src_byte),
    .cfg      (cfg),
    .item     (item)
  );

  // output register plus padding sequencer
  bwc_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .item       (item),
    .can_take   (can_take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .is_pad     (is_pad),
    .frame_last (frame_last),
    .bad_window (bad_window)
  );

endmodule

`default_nettype wire

>>> sv/bwc_check.sv
`default_nettype none

module bwc_check (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic [bwc_pkg::BYTE_W-1:0] out_byte,
  input wire logic                       is_pad,
  input wire logic                       frame_last,
  input wire logic                       bad_window
);

  // held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(is_pad) &&
      $stable(frame_last) && $stable(bad_window))
    else $error("stalled result changed");

  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_bad: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_window |-> out_byte == '0 && !is_pad && !frame_last)
    else $error("bad window result carries data");

  a_pad: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_pad |-> out_byte == '0 && !bad_window)
    else $error("padding byte not zero");

endmodule

bind bmp_window_crop bwc_check u_bwc_check (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_byte   (out_byte),
  .is_pad     (is_pad),
  .frame_last (frame_last),
  .bad_window (bad_window)
);

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import bwc_pkg::*;

  localparam int CYCLE_LIMIT   = 200_000;  // generous watchdog, in clk cycles
  localparam int SETTLE_CYCLES = 8;        // output register plus padding burst, with margin
  localparam int RANDOM_BYTES  = 320;
  localparam int MAX_REPORTS   = 20;       // keep the log short on a badly broken build

  // Indexes the block does not decode: a write there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  // Traffic shapes: source gaps and sink stalls, in percent of cycles
  typedef enum {FLOW_FREE, FLOW_SRC_GAPS, FLOW_SINK_STALLS, FLOW_LIGHT} flow_t;

  // One output transfer
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              pad;
    logic              last;
    logic              bad;
  } crop_beat_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SRC_WIDTH;
  logic [DIM_W-1:0]     cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [BYTE_W-1:0]    src_byte  = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [BYTE_W-1:0]    out_byte;
  logic                 is_pad;
  logic                 frame_last;
  logic                 bad_window;

  bmp_window_crop dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .src_byte   (src_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .is_pad     (is_pad),
    .frame_last (frame_last),
    .bad_window (bad_window)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Source bytes waiting for the driver, and output bytes the crop owes us
  logic [BYTE_W-1:0] src_bytes [$];
  crop_beat_t        beats_due [$];

  // Shadow of the crop registers and the row counters
  logic [DIM_W-1:0] img_w, img_h, crop_w, crop_h;
  logic [OFS_W-1:0] crop_x, crop_y;
  logic [POS_W-1:0] byte_pos;
  logic [ROW_W-1:0] row_idx;

  logic src_took = 1'b0;   // source transfer at the last rising edge
  int   src_gap_pct = 0;
  int   sink_stall_pct = 0;

  int errors = 0;
  int cycles = 0;
  int bytes_taken = 0;
  int checked = 0;
  int pads_seen = 0;
  int lasts_seen = 0;
  int bads_seen = 0;
  int window_settings = 0;

  function automatic bit dim_legal(input int unsigned d);
    return d >= 1 && d <= MAX_DIM;
  endfunction

  function automatic crop_beat_t beat(input logic [BYTE_W-1:0] data, input bit pad,
                                      input bit last, input bit bad);
    crop_beat_t b;
    b.data = data;
    b.pad  = pad;
    b.last = last;
    b.bad  = bad;
    return b;
  endfunction

  // Work out what one accepted source byte produces and advance the counters.
  // Rows arrive bottom-up; the window is given top-down, so its first row in
  // stream order is img_h - (crop_y + crop_h).
  function automatic void predict_crop(input logic [BYTE_W-1:0] b);
    int unsigned w, h, x, y, cw, ch;
    int unsigned stride, bottom, first, stop, padn, pos, row, k;
    bit last_row;
    w  = img_w;
    h  = img_h;
    x  = crop_x;
    y  = crop_y;
    cw = crop_w;
    ch = crop_h;
    // Illegal window: one flagged beat per byte, counters frozen
    if (!dim_legal(w) || !dim_legal(h) || !dim_legal(cw) || !dim_legal(ch) ||
        x + cw > w || y + ch > h) begin
      beats_due.push_back(beat('0, 1'b0, 1'b0, 1'b1));
      return;
    end
    stride = (3 * w + 3) & ~32'd3;
    bottom = h - (y + ch);
    first  = 3 * x;
    stop   = 3 * (x + cw);
    padn   = cw & 3;
    pos    = byte_pos;
    row    = row_idx;
    if (row >= bottom && row < bottom + ch && pos >= first && pos < stop) begin
      last_row = (row == bottom + ch - 1);
      if (pos == stop - 1) begin
        // closing pixel byte of a kept row, then the destination padding
        beats_due.push_back(beat(b, 1'b0, last_row && padn == 0, 1'b0));
        for (k = 0; k < padn; k++)
          beats_due.push_back(beat('0, 1'b1, last_row && k == padn - 1, 1'b0));
      end else begin
        beats_due.push_back(beat(b, 1'b0, 1'b0, 1'b0));
      end
    end
    // Counters wrap at their limits; one left past a new limit wraps on this advance
    if (pos + 1 >= stride) begin
      byte_pos = '0;
      row_idx  = (row + 1 >= h) ? '0 : ROW_W'(row + 1);
    end else begin
      byte_pos = POS_W'(pos + 1);
    end
  endfunction

  task automatic note_mismatch(input string field, input logic [BYTE_W-1:0] want,
                               input logic [BYTE_W-1:0] got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
  endtask

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: watchdog expired, %0d output bytes still owed", $time, beats_due.size());
      $display("tb_top failed");
      $finish;
    end
  end

  // Driver: new source byte on the falling edge once the previous one is
  // gone; a stalled byte stays put. Sink stall is drawn every cycle.
  always @(negedge clk) begin : driver
    logic go;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || src_took) begin
      go = (src_bytes.size() != 0) && ($urandom_range(0, 99) >= src_gap_pct);
      if (go)
        src_byte <= src_bytes.pop_front();
      in_valid <= go;
    end
    out_stall <= !rst && ($urandom_range(0, 99) < sink_stall_pct);
  end

  // Monitor: register writes and source transfers feed the predictor;
  // each output transfer is checked against the oldest owed byte.
  always @(posedge clk) begin : monitor
    crop_beat_t want, got;
    src_took <= in_valid && !in_stall;
    if (rst) begin
      // reset defaults: 1x1 image, 1x1 window at the origin
      img_w    = 1;
      img_h    = 1;
      crop_x   = 0;
      crop_y   = 0;
      crop_w   = 1;
      crop_h   = 1;
      byte_pos = '0;
      row_idx  = '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_SRC_WIDTH:  img_w  = cfg_data;
          REG_SRC_HEIGHT: img_h  = cfg_data;
          REG_WIN_LEFT:   crop_x = cfg_data[OFS_W-1:0];
          REG_WIN_TOP:    crop_y = cfg_data[OFS_W-1:0];
          REG_WIN_WIDTH:  crop_w = cfg_data;
          REG_WIN_HEIGHT: crop_h = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_crop(src_byte);
        bytes_taken++;
      end
      if (out_valid && !out_stall) begin
        got = {out_byte, is_pad, frame_last, bad_window};
        if (beats_due.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected output transfer, expected none, got %h", $time, got);
        end else begin
          want = beats_due.pop_front();
          if (got.data !== want.data) note_mismatch("out_byte", want.data, got.data);
          if (got.pad !== want.pad)   note_mismatch("is_pad", want.pad, got.pad);
          if (got.last !== want.last) note_mismatch("frame_last", want.last, got.last);
          if (got.bad !== want.bad)   note_mismatch("bad_window", want.bad, got.bad);
          checked++;
          pads_seen  += want.pad;
          lasts_seen += want.last;
          bads_seen  += want.bad;
        end
      end
    end
  end

  task automatic set_flow(input flow_t f);
    case (f)
      FLOW_FREE:        begin src_gap_pct = 0;  sink_stall_pct = 0;  end
      FLOW_SRC_GAPS:    begin src_gap_pct = 86; sink_stall_pct = 0;  end
      FLOW_SINK_STALLS: begin src_gap_pct = 0;  sink_stall_pct = 86; end
      default:          begin src_gap_pct = 9;  sink_stall_pct = 9;  end
    endcase
  endtask

  // Program all six registers, optionally poking the undecoded indexes too.
  // Only called with the block drained.
  task automatic set_window(input int sw, input int sh, input int wl, input int wt,
                            input int ww, input int wh, input bit spare);
    logic [CFG_IDX_W-1:0] idx [6];
    int vals [6];
    idx  = '{REG_SRC_WIDTH, REG_SRC_HEIGHT, REG_WIN_LEFT,
             REG_WIN_TOP, REG_WIN_WIDTH, REG_WIN_HEIGHT};
    vals = '{sw, sh, wl, wt, ww, wh};
    for (int i = 0; i < 6; i++) begin
      @(negedge clk);
      cfg_write <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= DIM_W'(vals[i]);
    end
    if (spare) begin
      @(negedge clk);
      cfg_index <= REG_SPARE_A;
      cfg_data  <= DIM_W'($urandom);
      @(negedge clk);
      cfg_index <= REG_SPARE_B;
      cfg_data  <= DIM_W'($urandom);
    end
    @(negedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    window_settings++;
  endtask

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++)
      src_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
  endtask

  // Hold the source until every owed byte has come out, then let the
  // pipeline settle (a dropped byte produces nothing to wait on).
  task automatic wait_drained();
    while (src_bytes.size() != 0 || in_valid || beats_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int sw, sh, wl, wt, ww, wh, frame, nbytes, phase, rand_bytes;
    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    @(posedge clk);

    // --- directed ---
    set_flow(FLOW_FREE);
    // reset defaults: 3 pixel bytes, one padding byte closing the frame, source pad dropped
    src_bytes.push_back(8'h00);
    src_bytes.push_back(8'hFF);
    src_bytes.push_back(8'hA5);
    src_bytes.push_back(8'h5A);
    wait_drained();
    // tallest image, window on its bottom row (first row in stream order); spare indexes poked
    set_window(1, 4096, 0, 4095, 1, 1, 1'b1);
    send_random(4);
    wait_drained();
    // three-pixel rows: most beats per byte (pixel plus three padding bytes)
    set_window(3, 2, 0, 0, 3, 2, 1'b0);
    send_random(12);
    wait_drained();
    // largest image and window, both fully legal
    set_window(4096, 4096, 0, 0, 4096, 4096, 1'b0);
    send_random(3);
    wait_drained();
    // rightmost one-pixel window: legal, nothing kept this early in the frame
    set_window(4096, 4096, 4095, 0, 1, 1, 1'b0);
    send_random(1);
    wait_drained();
    // illegal windows: zero dimension, oversize everything, too wide, too tall
    set_window(0, 1, 0, 0, 1, 1, 1'b0);
    send_random(1);
    wait_drained();
    set_window(8191, 8191, 8191, 8191, 8191, 8191, 1'b0);
    send_random(1);
    wait_drained();
    set_window(8, 8, 6, 0, 3, 1, 1'b0);
    send_random(1);
    wait_drained();
    set_window(8, 8, 0, 5, 1, 4, 1'b0);
    send_random(1);
    wait_drained();

    // --- random: mostly whole frames of small images, some noise ---
    phase = 0;
    rand_bytes = 0;
    while (rand_bytes < RANDOM_BYTES) begin
      set_flow(flow_t'(phase % 4));
      if (phase % 5 == 4) begin
        // arbitrary register values, almost always an illegal window
        set_window($urandom_range(0, 8191), $urandom_range(0, 8191), $urandom_range(0, 8191),
                   $urandom_range(0, 8191), $urandom_range(0, 8191), $urandom_range(0, 8191),
                   $urandom_range(0, 1));
        nbytes = $urandom_range(4, 12);
        send_random(nbytes);
      end else begin
        sw = $urandom_range(1, 6);
        sh = $urandom_range(1, 5);
        ww = $urandom_range(1, sw);
        wl = $urandom_range(0, sw - ww);
        wh = $urandom_range(1, sh);
        wt = $urandom_range(0, sh - wh);
        set_window(sw, sh, wl, wt, ww, wh, 1'b0);
        frame  = ((3 * sw + 3) & ~3) * sh;
        nbytes = frame * (1 + 40 / frame);
        // now and then cut a frame short, leaving the counters mid-frame
        if ($urandom_range(0, 4) == 0)
          nbytes = $urandom_range(1, nbytes - 1);
        if (phase == 2) begin
          // source holds off mid-stream until everything owed has come out
          send_random(nbytes / 2);
          wait_drained();
          send_random(nbytes - nbytes / 2);
        end else begin
          send_random(nbytes);
        end
      end
      rand_bytes += nbytes;
      wait_drained();
      phase++;
    end

    $display("Run covered %0d source bytes over %0d window settings,", bytes_taken,
             window_settings);
    $display("legal and illegal, with source gaps and sink stalls; %0d output bytes checked %s",
             checked, $sformatf("(%0d padding, %0d frame ends, %0d bad-window).",
                                pads_seen, lasts_seen, bads_seen));
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
